FILE: rtl/multiset_bag_table_assert.svh
// Assertion macros shared by the checker files of the bag table.
// Clock aclk and active-low reset aresetn must be visible where used.
`ifndef MULTISET_BAG_TABLE_ASSERT_SVH
`define MULTISET_BAG_TABLE_ASSERT_SVH

// Implication in the same cycle.
`define MBT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle.
`define MBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mbt_pkg.sv
// Package for the bag table: sizes, opcodes, item structs, FSM states.
// No dependencies.
package mbt_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FIELD_W     = 5;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic               success;
        logic [FIELD_W-1:0] frequency;
        logic [FIELD_W-1:0] size;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE
    } state_t;

    // Report a count in the 5-bit result fields (low bits kept).
    function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] x);
        logic [CNT_W+FIELD_W-1:0] ext;
        begin
            ext = {{FIELD_W{1'b0}}, x};
            return ext[FIELD_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/multiset_bag_table.sv
// Top level of the bag table: handshake, scan sequencer, entry RAM.
// Depends on mbt_pkg and mbt_ram.
//
// Usage: s_item (opcode, value) enters on s_valid/s_ready; one m_item
// (success, frequency, size) leaves per item on m_valid/m_ready.
// Entries live in a RAM of CAPACITY words with a registered read.
// Add and clear finish in the accept cycle: the result is valid on the
// next cycle. Remove and query scan the stored entries one per cycle
// through the RAM read port (on an empty bag they fail in the accept
// cycle); a query or a missed remove reads every stored entry. A remove
// stops at its first match, then reads the last entry and writes it
// into the freed slot.
// One item is worked on at a time; s_ready is high only when the
// sequencer is idle and the result register is empty or being taken.
// A stalled m_ready holds the result and blocks new items.
// Reset (aresetn low, synchronous) empties the bag and drops any result;
// the RAM contents are not cleared, since only the first size entries
// are ever read.
module multiset_bag_table
    import mbt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       freq_reg, freq_next;
    logic [ADDR_W-1:0]      idx_reg, idx_next;
    logic [ADDR_W-1:0]      pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    op_t                    op_reg, op_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_item_reg, m_item_next;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

    logic                   accept;
    logic [63:0]            in_wide;
    logic [VALUE_WIDTH-1:0] in_val;
    logic [CNT_W-1:0]       count_dec;
    logic [ADDR_W-1:0]      last_addr;
    logic [CNT_W+ADDR_W-1:0] idx_ext;
    logic                   idx_last;
    logic                   hit;

    // Entry store
    mbt_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Helpers for the scan
    assign in_wide   = {32'b0, s_item.value};
    assign in_val    = in_wide[VALUE_WIDTH-1:0];
    assign count_dec = count_reg - CNT_W'(1);
    assign last_addr = count_dec[ADDR_W-1:0];
    assign idx_ext   = {{CNT_W{1'b0}}, idx_reg};
    assign idx_last  = (idx_ext[CNT_W-1:0] == count_dec);
    assign hit       = (ram_rdata == val_reg);

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Sequencer: next state, RAM access and result
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        freq_next    = freq_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        op_next      = op_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        ram_we       = 1'b0;
        ram_waddr    = count_reg[ADDR_W-1:0];
        ram_wdata    = in_val;
        ram_raddr    = idx_reg + ADDR_W'(1);

        unique case (state_reg)
            ST_IDLE: begin
                ram_raddr = '0;
                if (accept) begin
                    val_next  = in_val;
                    op_next   = op_t'(s_item.opcode);
                    freq_next = '0;
                    idx_next  = '0;
                    unique case (op_t'(s_item.opcode))
                        OP_ADD: begin
                            m_valid_next = 1'b1;
                            if (count_reg < CNT_W'(CAPACITY)) begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                m_item_next = '{1'b1, '0, to_field(count_reg + CNT_W'(1))};
                            end else begin
                                m_item_next = '{1'b0, '0, to_field(count_reg)};
                            end
                        end
                        OP_CLEAR: begin
                            count_next   = '0;
                            m_valid_next = 1'b1;
                            m_item_next  = '{1'b1, '0, '0};
                        end
                        default: begin
                            // remove or query: scan unless empty
                            if (count_reg == '0) begin
                                m_valid_next = 1'b1;
                                m_item_next  = '{1'b0, '0, '0};
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (op_reg == OP_REMOVE) begin
                    if (hit) begin
                        // fetch the last entry to fill the freed slot
                        pos_next   = idx_reg;
                        ram_raddr  = last_addr;
                        state_next = ST_MOVE;
                    end else if (idx_last) begin
                        state_next   = ST_IDLE;
                        m_valid_next = 1'b1;
                        m_item_next  = '{1'b0, '0, to_field(count_reg)};
                    end else begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end else begin
                    freq_next = freq_reg + CNT_W'(hit);
                    if (idx_last) begin
                        state_next   = ST_IDLE;
                        m_valid_next = 1'b1;
                        m_item_next  = '{(freq_next != '0), to_field(freq_next),
                                         to_field(count_reg)};
                    end else begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
            ST_MOVE: begin
                ram_we       = 1'b1;
                ram_waddr    = pos_reg;
                ram_wdata    = ram_rdata;
                count_next   = count_dec;
                state_next   = ST_IDLE;
                m_valid_next = 1'b1;
                m_item_next  = '{1'b1, '0, to_field(count_dec)};
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        freq_reg   <= freq_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        op_reg     <= op_next;
        m_item_reg <= m_item_next;
    end

endmodule

FILE: rtl/mbt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/mbt_checker.sv
// Port-level checks for the bag table, bound to the top level.
// Depends on mbt_pkg and multiset_bag_table_assert.svh.
`include "multiset_bag_table_assert.svh"

module mbt_checker
    import mbt_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // a stalled result holds
    `MBT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_item), "result changed while stalled")
    // no new item while a result is stuck
    `MBT_ASSERT_NOW(a_no_accept_stalled, m_valid && !m_ready, !s_ready, "item taken while result stalled")
    // size never exceeds the capacity
    `MBT_ASSERT_NOW(a_size_cap, m_valid, m_item.size <= FIELD_W'(CAPACITY), "size above capacity")
    // a nonzero count implies success and fits within the size
    `MBT_ASSERT_NOW(a_freq_ok, m_valid && m_item.frequency != '0, m_item.success && (m_item.frequency <= m_item.size), "frequency inconsistent")

endmodule

bind multiset_bag_table mbt_checker u_mbt_checker (.*);

FILE: tb/multiset_bag_table_tb.sv
// Self-checking testbench for the bag table: directed rows, then random traffic
// under several idle/stall mixes, each result checked against the table or a local predictor.
// Depends on mbt_pkg and multiset_bag_table.
module multiset_bag_table_tb
    import mbt_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = CAPACITY + 4;
    localparam int MAX_REPORTS = 10;
    localparam int NUM_ROWS    = 25;
    localparam int RAND_ITEMS  = 88;

    // One row of the directed table; want is used only when typed is set
    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } bag_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    // Predictor state: stored entries and their count
    logic [VALUE_WIDTH-1:0] bag_store [CAPACITY];
    int                     bag_count;

    out_item_t   expected_results [$];
    logic [31:0] value_pool [5];
    bag_row_t    bag_rows [NUM_ROWS];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int cycle_count;

    multiset_bag_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Apply one item to the predicted bag and return its result
    function automatic out_item_t bag_apply(input in_item_t it);
        out_item_t              r;
        logic [VALUE_WIDTH-1:0] v;
        int                     hit;
        int                     n;
        r   = '0;
        v   = it.value[VALUE_WIDTH-1:0];
        hit = -1;
        n   = 0;
        case (op_t'(it.opcode))
            OP_ADD: begin
                if (bag_count < CAPACITY) begin
                    bag_store[bag_count] = v;
                    bag_count++;
                    r.success = 1'b1;
                end
            end
            OP_REMOVE: begin
                for (int i = 0; i < bag_count; i++) begin
                    if (hit < 0 && bag_store[i] == v) hit = i;
                end
                // last entry fills the freed slot
                if (hit >= 0) begin
                    bag_count--;
                    bag_store[hit] = bag_store[bag_count];
                    r.success = 1'b1;
                end
            end
            OP_QUERY: begin
                for (int i = 0; i < bag_count; i++) begin
                    if (bag_store[i] == v) n++;
                end
                r.frequency = FIELD_W'(n);
                r.success   = (n != 0);
            end
            default: begin
                bag_count = 0;
                r.success = 1'b1;
            end
        endcase
        r.size = FIELD_W'(bag_count);
        return r;
    endfunction

    function automatic in_item_t mk_item(input op_t op, input logic [31:0] value);
        in_item_t it;
        it.opcode = op;
        it.value  = value;
        return it;
    endfunction

    // Values mostly from a small pool so that duplicates and hits are common
    function automatic logic [31:0] pick_value();
        int k;
        k = $urandom_range(7);
        if (k == 0) return 32'h0;
        if (k == 1) return 32'hFFFF_FFFF;
        if (k == 7) return $urandom;
        return value_pool[k - 2];
    endfunction

    function automatic in_item_t gen_bag_item();
        int          r;
        logic [31:0] v;
        r = $urandom_range(99);
        v = pick_value();
        // remove and query often target a stored entry
        if (r >= 45 && r < 95 && bag_count > 0 && $urandom_range(1) == 1)
            v = bag_store[$urandom_range(bag_count - 1)];
        if (r < 45) return mk_item(OP_ADD, v);
        if (r < 70) return mk_item(OP_REMOVE, v);
        if (r < 95) return mk_item(OP_QUERY, v);
        return mk_item(OP_CLEAR, $urandom);
    endfunction

    // Offer one item; entered and left at a falling edge
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t got;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = bag_apply(it);
        expected_results = {expected_results, (typed ? want : got)};
        @(negedge aclk);
    endtask

    task automatic send_random(input in_item_t it);
        send_item(it, 1'b0, '0);
    endtask

    // Hold off the sender until every result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_results.size() != 0) @(negedge aclk);
    endtask

    // Clear, fill with one value, hit the full and all-equal cases, take a few out
    task automatic run_fill_sequence();
        logic [31:0] v;
        v = pick_value();
        send_random(mk_item(OP_CLEAR, $urandom));
        repeat (CAPACITY) send_random(mk_item(OP_ADD, v));
        send_random(mk_item(OP_QUERY, v));
        send_random(mk_item(OP_ADD, ~v));
        repeat (3) send_random(mk_item(OP_REMOVE, v));
        send_random(mk_item(OP_QUERY, v));
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        run_fill_sequence();
        repeat (RAND_ITEMS) send_random(gen_bag_item());
        drain_results();
    endtask

    function automatic bag_row_t mk_row(input op_t op, input logic [31:0] value,
                                        input bit typed, input bit ok,
                                        input int freq, input int size);
        bag_row_t row;
        row.item           = mk_item(op, value);
        row.typed          = typed;
        row.want.success   = ok;
        row.want.frequency = FIELD_W'(freq);
        row.want.size      = FIELD_W'(size);
        return row;
    endfunction

    // Receiver stalls
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: success=%0d frequency=%0d size=%0d",
                             m_item.success, m_item.frequency, m_item.size);
            end else begin
                out_item_t want;
                want = expected_results.pop_front();
                if (m_item.success !== want.success || m_item.frequency !== want.frequency
                        || m_item.size !== want.size) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.success, want.frequency, want.size,
                                 m_item.success, m_item.frequency, m_item.size);
                end
            end
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("multiset_bag_table_tb failed");
            $finish;
        end
    end

    initial begin
        int r;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_item         = '0;
        m_ready        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        cycle_count    = 0;
        bag_count      = 0;
        foreach (value_pool[i]) value_pool[i] = $urandom;

        // Directed rows: empty bag, extremes, duplicates, fill to full, clear
        bag_rows[0] = mk_row(OP_QUERY,  32'h0,         1, 0, 0, 0);
        bag_rows[1] = mk_row(OP_REMOVE, 32'hFFFF_FFFF, 1, 0, 0, 0);
        bag_rows[2] = mk_row(OP_ADD,    32'h0,         1, 1, 0, 1);
        bag_rows[3] = mk_row(OP_ADD,    32'hFFFF_FFFF, 1, 1, 0, 2);
        bag_rows[4] = mk_row(OP_ADD,    32'hFFFF_FFFF, 1, 1, 0, 3);
        bag_rows[5] = mk_row(OP_QUERY,  32'hFFFF_FFFF, 1, 1, 2, 3);
        bag_rows[6] = mk_row(OP_REMOVE, 32'hFFFF_FFFF, 1, 1, 0, 2);
        for (int i = 7; i < 21; i++)
            bag_rows[i] = mk_row(OP_ADD, (i % 3 == 0) ? 32'h0 : $urandom, 0, 0, 0, 0);
        bag_rows[21] = mk_row(OP_ADD,   32'h1234_5678, 1, 0, 0, 16);
        bag_rows[22] = mk_row(OP_QUERY, 32'h0,         0, 0, 0, 0);
        bag_rows[23] = mk_row(OP_REMOVE, 32'h0,        0, 0, 0, 0);
        bag_rows[24] = mk_row(OP_CLEAR, 32'hA5A5_A5A5, 1, 1, 0, 0);

        // Synchronous reset, asserted once
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (bag_rows[i]) send_item(bag_rows[i].item, bag_rows[i].typed, bag_rows[i].want);
        drain_results();

        run_phase(0, 0);
        run_phase(73, 0);
        run_phase(0, 73);
        run_phase(27, 27);
        run_phase(0, 0);

        // Tail: wait for stragglers and any stray results
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        r = mismatches + expected_results.size();
        if (r == 0) begin
            $display("multiset_bag_table_tb passed");
        end else begin
            $display("multiset_bag_table_tb failed");
        end
        $finish;
    end

endmodule
